/* src/vbb_pkg.sv */
// Shared types, widths and register codes for the transformed vertex bounding box block.
package vbb_pkg;

    localparam int COORD_W   = 32;
    localparam int PROD_W    = 2 * COORD_W;
    localparam int PAIR_W    = PROD_W + 1;
    localparam int SUM_W     = PROD_W + 2;
    localparam int FRAC_BITS = 16;

    localparam int NUM_TERMS = 4;
    localparam int NUM_LANES = 2;
    localparam int NUM_REGS  = NUM_LANES * NUM_TERMS;
    localparam int CFG_IDX_W = $clog2(NUM_REGS);

    // Lanes of the transform: one per matrix row that is used.
    localparam int LANE_X = 0;
    localparam int LANE_Y = 1;

    // Vertex component order inside a row.
    localparam int TERM_X = 0;
    localparam int TERM_Y = 1;
    localparam int TERM_Z = 2;
    localparam int TERM_W = 3;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_ROW_X_COEF_X = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ROW_X_COEF_Y = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_ROW_X_COEF_Z = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_ROW_X_COEF_W = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_ROW_Y_COEF_X = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_ROW_Y_COEF_Y = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] REG_ROW_Y_COEF_Z = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] REG_ROW_Y_COEF_W = CFG_IDX_W'(7);

    typedef logic signed [COORD_W-1:0] q16_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [PAIR_W-1:0]  pair_t;
    typedef logic signed [SUM_W-1:0]   sum_t;

    localparam q16_t ONE_Q16   = 32'sh0001_0000;
    localparam q16_t COORD_MAX = 32'sh7fff_ffff;
    localparam q16_t COORD_MIN = 32'sh8000_0000;

    typedef struct packed {
        q16_t vert_x;
        q16_t vert_y;
        q16_t vert_z;
        q16_t vert_w;
        logic last_vertex;
    } vertex_t;

    typedef struct packed {
        q16_t box_min_x;
        q16_t box_min_y;
        q16_t box_max_x;
        q16_t box_max_y;
    } box_t;

    // One transformed point on its way to the bounds tracker.
    typedef struct packed {
        q16_t pos_x;
        q16_t pos_y;
        logic last_vertex;
    } point_t;

endpackage

/* src/vbb_mul.sv */
// Product stage: the eight coefficient by component products of one vertex, registered.
module vbb_mul (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             up_valid,
    output logic             up_ready,
    input  vbb_pkg::vertex_t up_word,
    input  vbb_pkg::q16_t    coef [vbb_pkg::NUM_LANES][vbb_pkg::NUM_TERMS],
    output logic             dn_valid,
    input  logic             dn_ready,
    output vbb_pkg::prod_t   prod [vbb_pkg::NUM_LANES][vbb_pkg::NUM_TERMS],
    output logic             dn_last
);
    import vbb_pkg::*;

    logic  valid_reg;
    logic  last_reg;
    prod_t prod_reg  [NUM_LANES][NUM_TERMS];
    prod_t prod_next [NUM_LANES][NUM_TERMS];
    q16_t  comp      [NUM_TERMS];
    logic  take;

    assign up_ready = !valid_reg || dn_ready;
    assign take     = up_valid && up_ready;

    always_comb
    begin
        comp[TERM_X] = up_word.vert_x;
        comp[TERM_Y] = up_word.vert_y;
        comp[TERM_Z] = up_word.vert_z;
        comp[TERM_W] = up_word.vert_w;
        for (int l = 0; l < NUM_LANES; l++)
        begin
            for (int t = 0; t < NUM_TERMS; t++)
            begin
                prod_next[l][t] = PROD_W'(coef[l][t]) * PROD_W'(comp[t]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            prod_reg <= prod_next;
            last_reg <= up_word.last_vertex;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_last  = last_reg;
    assign prod     = prod_reg;

endmodule

/* src/vbb_reduce.sv */
// Reduction stages: pairwise sums, then the row sum, floor shift and saturation to Q16.16.
module vbb_reduce (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            up_valid,
    output logic            up_ready,
    input  vbb_pkg::prod_t  prod [vbb_pkg::NUM_LANES][vbb_pkg::NUM_TERMS],
    input  logic            up_last,
    output logic            dn_valid,
    input  logic            dn_ready,
    output vbb_pkg::point_t dn_point
);
    import vbb_pkg::*;

    localparam sum_t SAT_HI = sum_t'(COORD_MAX);
    localparam sum_t SAT_LO = sum_t'(COORD_MIN);

    logic  pair_valid_reg;
    logic  pair_last_reg;
    pair_t pair_reg  [NUM_LANES][2];
    pair_t pair_next [NUM_LANES][2];
    logic  pair_ready;

    logic  coord_valid_reg;
    logic  coord_last_reg;
    q16_t  coord_reg  [NUM_LANES];
    q16_t  coord_next [NUM_LANES];
    sum_t  row_sum    [NUM_LANES];
    sum_t  row_shift  [NUM_LANES];

    assign pair_ready = !coord_valid_reg || dn_ready;
    assign up_ready   = !pair_valid_reg || pair_ready;

    always_comb
    begin
        for (int l = 0; l < NUM_LANES; l++)
        begin
            pair_next[l][0] = PAIR_W'(prod[l][TERM_X]) + PAIR_W'(prod[l][TERM_Y]);
            pair_next[l][1] = PAIR_W'(prod[l][TERM_Z]) + PAIR_W'(prod[l][TERM_W]);
        end
    end

    // The arithmetic shift of the full sum rounds toward minus infinity.
    always_comb
    begin
        for (int l = 0; l < NUM_LANES; l++)
        begin
            row_sum[l]   = SUM_W'(pair_reg[l][0]) + SUM_W'(pair_reg[l][1]);
            row_shift[l] = row_sum[l] >>> FRAC_BITS;
            if (row_shift[l] > SAT_HI)
            begin
                coord_next[l] = COORD_MAX;
            end
            else if (row_shift[l] < SAT_LO)
            begin
                coord_next[l] = COORD_MIN;
            end
            else
            begin
                coord_next[l] = row_shift[l][COORD_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_valid_reg  <= 1'b0;
            coord_valid_reg <= 1'b0;
        end
        else
        begin
            if (up_ready)
            begin
                pair_valid_reg <= up_valid;
            end
            if (pair_ready)
            begin
                coord_valid_reg <= pair_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            pair_reg      <= pair_next;
            pair_last_reg <= up_last;
        end
        if (pair_valid_reg && pair_ready)
        begin
            coord_reg      <= coord_next;
            coord_last_reg <= pair_last_reg;
        end
    end

    assign dn_valid             = coord_valid_reg;
    assign dn_point.pos_x       = coord_reg[LANE_X];
    assign dn_point.pos_y       = coord_reg[LANE_Y];
    assign dn_point.last_vertex = coord_last_reg;

endmodule

/* src/vbb_bounds.sv */
// Running bounds of the current set and the registered box output.
module vbb_bounds (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            up_valid,
    output logic            up_ready,
    input  vbb_pkg::point_t up_point,
    output logic            out_valid,
    input  logic            out_stall,
    output vbb_pkg::box_t   out_word
);
    import vbb_pkg::*;

    logic awaiting_first_reg;
    q16_t run_min_x_reg;
    q16_t run_min_y_reg;
    q16_t run_max_x_reg;
    q16_t run_max_y_reg;
    q16_t run_min_x_next;
    q16_t run_min_y_next;
    q16_t run_max_x_next;
    q16_t run_max_y_next;
    logic out_valid_reg;
    box_t box_reg;
    logic take;

    // A point that closes a set waits only when the output register is full and stalled.
    assign up_ready = !up_point.last_vertex || !out_valid_reg || !out_stall;
    assign take     = up_valid && up_ready;

    always_comb
    begin
        run_min_x_next = (awaiting_first_reg || up_point.pos_x < run_min_x_reg)
                         ? up_point.pos_x : run_min_x_reg;
        run_max_x_next = (awaiting_first_reg || up_point.pos_x > run_max_x_reg)
                         ? up_point.pos_x : run_max_x_reg;
        run_min_y_next = (awaiting_first_reg || up_point.pos_y < run_min_y_reg)
                         ? up_point.pos_y : run_min_y_reg;
        run_max_y_next = (awaiting_first_reg || up_point.pos_y > run_max_y_reg)
                         ? up_point.pos_y : run_max_y_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaiting_first_reg <= 1'b1;
            run_min_x_reg      <= '0;
            run_min_y_reg      <= '0;
            run_max_x_reg      <= '0;
            run_max_y_reg      <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                awaiting_first_reg <= up_point.last_vertex;
                run_min_x_reg      <= run_min_x_next;
                run_min_y_reg      <= run_min_y_next;
                run_max_x_reg      <= run_max_x_next;
                run_max_y_reg      <= run_max_y_next;
            end
            if (take && up_point.last_vertex)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && up_point.last_vertex)
        begin
            box_reg.box_min_x <= run_min_x_next;
            box_reg.box_min_y <= run_min_y_next;
            box_reg.box_max_x <= run_max_x_next;
            box_reg.box_max_y <= run_max_y_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = box_reg;

    // A box on the output is never inverted.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (box_reg.box_min_x <= box_reg.box_max_x &&
                           box_reg.box_min_y <= box_reg.box_max_y))
        else $error("box minimum exceeds maximum");

    // Closing a set rearms the tracker and presents a box.
    assert property (@(posedge clk) disable iff (!rst_n)
        (take && up_point.last_vertex) |=> (awaiting_first_reg && out_valid_reg))
        else $error("set end did not rearm or emit");

    // A point inside a set leaves the tracker mid-set with ordered bounds.
    assert property (@(posedge clk) disable iff (!rst_n)
        (take && !up_point.last_vertex) |=>
            (!awaiting_first_reg && run_min_x_reg <= run_max_x_reg &&
             run_min_y_reg <= run_max_y_reg))
        else $error("running bounds out of order");

endmodule

/* src/transformed_vertex_bounding_box_core.sv */
// Top level of the transformed vertex bounding box core: configuration and pipeline.
//
// The core takes homogeneous Q16.16 vertices, one word per cycle unless in_stall is high,
// transforms each by the first two rows of the configured matrix, and tracks the minimum
// and maximum of transformed x and y over a set of vertices. The vertex flagged last_vertex
// closes the set: one box word (min x, min y, max x, max y) follows on the output and the
// next vertex starts a new set. Each coordinate is the full-width sum of four 32 by 32
// products, shifted right by 16 (rounding toward minus infinity) and saturated to 32 bits.
// A vertex is accepted every cycle unless in_stall is high; the rate is set by the eight
// 32 by 32 multipliers working in parallel in their own pipeline stage. After the closing
// vertex is accepted, the box passes the input register, products, pair sums, row sum with
// saturation, and the bounds and output register. The user must write the coefficient
// registers through the plain write port only while the core is idle; the core does not
// enforce this. The coefficient registers reset to the identity rows.
module transformed_vertex_bounding_box_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  vbb_pkg::vertex_t                   in_word,
    output logic                               out_valid,
    input  logic                               out_stall,
    output vbb_pkg::box_t                      out_word,
    input  logic                               cfg_wr_en,
    input  logic [vbb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  vbb_pkg::q16_t                      cfg_data
);
    import vbb_pkg::*;

    // Coefficient registers, in port index order.
    q16_t    coef_reg [NUM_REGS];
    q16_t    row_coef [NUM_LANES][NUM_TERMS];

    // Input register stage.
    logic    in_valid_reg;
    vertex_t in_word_reg;
    logic    in_ready;

    logic    mul_ready;
    logic    mul_valid;
    logic    mul_last;
    prod_t   mul_prod [NUM_LANES][NUM_TERMS];

    logic    red_ready;
    logic    red_valid;
    point_t  red_point;
    logic    bnd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg[REG_ROW_X_COEF_X] <= ONE_Q16;
            coef_reg[REG_ROW_X_COEF_Y] <= '0;
            coef_reg[REG_ROW_X_COEF_Z] <= '0;
            coef_reg[REG_ROW_X_COEF_W] <= '0;
            coef_reg[REG_ROW_Y_COEF_X] <= '0;
            coef_reg[REG_ROW_Y_COEF_Y] <= ONE_Q16;
            coef_reg[REG_ROW_Y_COEF_Z] <= '0;
            coef_reg[REG_ROW_Y_COEF_W] <= '0;
        end
        else if (cfg_wr_en)
        begin
            coef_reg[cfg_index] <= cfg_data;
        end
    end

    // Row x uses registers 0 to 3, row y registers 4 to 7, in x, y, z, w order.
    always_comb
    begin
        row_coef[LANE_X][TERM_X] = coef_reg[REG_ROW_X_COEF_X];
        row_coef[LANE_X][TERM_Y] = coef_reg[REG_ROW_X_COEF_Y];
        row_coef[LANE_X][TERM_Z] = coef_reg[REG_ROW_X_COEF_Z];
        row_coef[LANE_X][TERM_W] = coef_reg[REG_ROW_X_COEF_W];
        row_coef[LANE_Y][TERM_X] = coef_reg[REG_ROW_Y_COEF_X];
        row_coef[LANE_Y][TERM_Y] = coef_reg[REG_ROW_Y_COEF_Y];
        row_coef[LANE_Y][TERM_Z] = coef_reg[REG_ROW_Y_COEF_Z];
        row_coef[LANE_Y][TERM_W] = coef_reg[REG_ROW_Y_COEF_W];
    end

    // The input register takes a new word whenever it is empty or drains this cycle.
    assign in_ready = !in_valid_reg || mul_ready;
    assign in_stall = !in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_word_reg <= in_word;
        end
    end

    vbb_mul u_mul (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (in_valid_reg),
        .up_ready (mul_ready),
        .up_word  (in_word_reg),
        .coef     (row_coef),
        .dn_valid (mul_valid),
        .dn_ready (red_ready),
        .prod     (mul_prod),
        .dn_last  (mul_last)
    );

    vbb_reduce u_reduce (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (mul_valid),
        .up_ready (red_ready),
        .prod     (mul_prod),
        .up_last  (mul_last),
        .dn_valid (red_valid),
        .dn_ready (bnd_ready),
        .dn_point (red_point)
    );

    vbb_bounds u_bounds (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (red_valid),
        .up_ready  (bnd_ready),
        .up_point  (red_point),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

endmodule
